// File: hdl/bspc_pkg.sv
// bspc_pkg: shared widths, register indexes and queue entry type for the
// 1 bpp bitmap pixel coordinate block. No dependencies.
`default_nettype none
package bspc_pkg;

    localparam int DATA_W        = 8;
    localparam int COL_W         = 12;
    localparam int ROW_W         = 12;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    // one byte after width masking, with its column base and row
    typedef struct packed {
        logic [DATA_W-1:0]  bits;
        logic [COL_W-4:0]   col_hi;
        logic [ROW_W-1:0]   row;
    } t_entry;

    typedef struct packed {
        logic   empty;
        t_entry entry;
    } t_fifo_rd;

endpackage
`default_nettype wire

// File: hdl/bspc_front.sv
// bspc_front: configuration registers, byte and row position tracking,
// width masking of each accepted byte. Depends on bspc_pkg.
`default_nettype none
module bspc_front #(
    parameter int MAX_WIDTH  = bspc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bspc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [bspc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bspc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic [bspc_pkg::DATA_W-1:0]    i_data_byte,
    output logic                                o_push,
    output bspc_pkg::t_entry                    o_entry
);
    import bspc_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int BW   = $clog2(((MAX_WIDTH + 31) / 32) * 4);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMPW = (BW + 3 > WW) ? BW + 3 : WW;

    logic [WW-1:0] r_eff_w,     n_eff_w;
    logic [BW-1:0] r_last_byte, n_last_byte;
    logic [RW-1:0] r_top_row,   n_top_row;
    logic [BW-1:0] r_byte,      n_byte;
    logic [RW-1:0] r_row,       n_row;
    logic [DATA_W-1:0] mask;
    int w_clamp;
    int h_clamp;

    always_comb begin
        w_clamp = int'(i_cfg_data);
        if (w_clamp < 1) w_clamp = 1;
        if (w_clamp > MAX_WIDTH) w_clamp = MAX_WIDTH;
        h_clamp = int'(i_cfg_data);
        if (h_clamp < 1) h_clamp = 1;
        if (h_clamp > MAX_HEIGHT) h_clamp = MAX_HEIGHT;

        n_eff_w     = r_eff_w;
        n_last_byte = r_last_byte;
        n_top_row   = r_top_row;
        n_byte      = r_byte;
        n_row       = r_row;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH: begin
                    n_eff_w     = WW'(w_clamp);
                    n_last_byte = BW'((((w_clamp + 31) >> 5) << 2) - 1);
                    n_byte      = '0;
                    n_row       = r_top_row;
                end
                CFG_IDX_HEIGHT: begin
                    n_top_row = RW'(h_clamp - 1);
                    n_byte    = '0;
                    n_row     = RW'(h_clamp - 1);
                end
                default: ;
            endcase
        end else if (i_accept) begin
            if (r_byte == r_last_byte) begin
                n_byte = '0;
                // end of frame wraps to the top stored row
                n_row  = (r_row == '0) ? r_top_row : r_row - 1'b1;
            end else begin
                n_byte = r_byte + 1'b1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < DATA_W; k++) begin
            mask[DATA_W-1-k] = (CMPW'({r_byte, 3'(k)}) < CMPW'(r_eff_w));
        end
        o_entry.bits   = i_data_byte & mask;
        o_entry.col_hi = (COL_W-3)'(r_byte);
        o_entry.row    = ROW_W'(r_row);
        o_push         = i_accept && (|o_entry.bits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w     <= WW'(1);
            r_last_byte <= BW'(3);
            r_top_row   <= '0;
            r_byte      <= '0;
            r_row       <= '0;
        end else begin
            r_eff_w     <= n_eff_w;
            r_last_byte <= n_last_byte;
            r_top_row   <= n_top_row;
            r_byte      <= n_byte;
            r_row       <= n_row;
        end
    end

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && (i_cfg_index == CFG_IDX_WIDTH || i_cfg_index == CFG_IDX_HEIGHT)
        |=> r_byte == '0 && r_row == r_top_row)
        else $error("config write did not restart the frame");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_cfg_valid && r_byte == r_last_byte && r_row == '0
        |=> r_row == r_top_row && r_byte == '0)
        else $error("frame did not wrap to top row");

endmodule
`default_nettype wire

// File: hdl/bspc_fifo.sv
// bspc_fifo: short queue of masked bytes between front and back end.
// Depends on bspc_pkg.
`default_nettype none
module bspc_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  bspc_pkg::t_entry      i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output bspc_pkg::t_fifo_rd    o_rd
);
    import bspc_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_entry        r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full      = (r_count == CW'(FIFO_DEPTH));
    assign o_rd.empty  = (r_count == '0);
    assign o_rd.entry  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: hdl/bspc_back.sv
// bspc_back: walks the set bits of one queued byte, msb first, and presents
// one pixel coordinate per cycle while i_stall is low. Depends on bspc_pkg.
`default_nettype none
module bspc_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  bspc_pkg::t_fifo_rd                i_rd,
    output logic                              o_pop,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [bspc_pkg::COL_W-1:0]        o_pixel_col,
    output logic [bspc_pkg::ROW_W-1:0]        o_pixel_row,
    output logic                              o_last
);
    import bspc_pkg::*;

    logic [DATA_W-1:0] r_bits;
    logic [COL_W-4:0]  r_col_hi;
    logic [ROW_W-1:0]  r_row;
    logic [2:0]        pos;
    logic [DATA_W-1:0] remain;
    logic              fire;

    always_comb begin
        pos = '0;
        // highest set bit is the leftmost remaining pixel
        for (int i = 0; i < DATA_W; i++) begin
            if (r_bits[i]) pos = 3'(i);
        end
        remain       = r_bits & ~(DATA_W'(1) << pos);
        o_valid      = |r_bits;
        o_last       = (remain == '0);
        o_pixel_col  = {r_col_hi, ~pos};
        o_pixel_row  = r_row;
        fire         = o_valid && !i_stall;
        o_pop        = (!o_valid || (fire && o_last)) && !i_rd.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (o_pop) begin
            r_bits <= i_rd.entry.bits;
        end else if (fire) begin
            r_bits <= remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_col_hi <= i_rd.entry.col_hi;
            r_row    <= i_rd.entry.row;
        end
    end

    a_more_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !o_last |=> o_valid && o_pixel_row == $past(o_pixel_row))
        else $error("byte ended before its last pixel");

    a_no_idle_with_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !i_rd.empty |-> o_pop)
        else $error("back end idle while queue holds work");

endmodule
`default_nettype wire

// File: hdl/bitmap_set_pixel_coordinates_top.sv
// Top level of the 1 bpp bitmap pixel coordinate block: front end, queue,
// back end. Depends on bspc_pkg, bspc_front, bspc_fifo, bspc_back.
//
// Takes bottom-up 1 bpp pixel bytes, one per request, and returns the column
// and row of every set pixel inside the image width, msb first, with o_last
// on the final pixel of each byte. Rows are padded to 32 bits; padding bits
// and bytes are consumed silently. The input side takes a byte every cycle
// while the four-entry queue has room; a byte with no visible set pixel
// never reaches the queue. The back end emits one coordinate per cycle while
// the output is not stalled, and the next queued byte's first pixel follows
// the last pixel of the byte before it without a gap. An accepted byte is
// registered in the queue, then in the back end's bit register, before its
// first result appears. Writing image_width or image_height restarts the frame at the top stored row.
`default_nettype none
module bitmap_set_pixel_coordinates_top #(
    parameter int MAX_WIDTH  = bspc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bspc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bspc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bspc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [bspc_pkg::DATA_W-1:0]    i_data_byte,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [bspc_pkg::COL_W-1:0]          o_pixel_col,
    output logic [bspc_pkg::ROW_W-1:0]          o_pixel_row,
    output logic                                o_last
);
    import bspc_pkg::*;

    logic     full;
    logic     accept;
    logic     push;
    logic     pop;
    t_entry   entry;
    t_fifo_rd rd;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign accept      = i_valid && !full;

    bspc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_entry     (entry)
    );

    bspc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_rd    (rd)
    );

    bspc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (rd),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_pixel_col (o_pixel_col),
        .o_pixel_row (o_pixel_row),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

// File: tb/sv/bitmap_set_pixel_coordinates_top_tb.sv
// Self-checking testbench for bitmap_set_pixel_coordinates_top: directed table, then random
// frames under bursty input and stalling output, checked against an in-bench unpacker.
// Depends on bspc_pkg and the block's RTL only.
`timescale 1ns / 100ps
`default_nettype none
module bitmap_set_pixel_coordinates_top_tb;
    import bspc_pkg::*;

    localparam int MAX_W           = DEF_MAX_WIDTH;
    localparam int MAX_H           = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LIMIT_CYCLES    = 100000;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int PRESSURE_PHASE  = 2;
    localparam int DRAIN_PHASE     = 5;
    localparam int HOLD_CYCLES     = 150;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef enum logic {STEP_CFG, STEP_PIX} t_step_kind;

    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        logic                 typed;
        logic                 hit;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
    } t_dir_step;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_pixel;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [DATA_W-1:0]    i_data_byte = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_stall;
    logic                 o_valid;
    logic [COL_W-1:0]     o_pixel_col;
    logic [ROW_W-1:0]     o_pixel_row;
    logic                 o_last;

    bitmap_set_pixel_coordinates_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_col (o_pixel_col),
        .o_pixel_row (o_pixel_row),
        .o_last      (o_last)
    );

    // unpacker state, mirrors the block
    logic [CFG_W-1:0] img_w    = 13'd1;
    logic [CFG_W-1:0] img_h    = 13'd1;
    int unsigned      byte_pos = 0;
    logic [ROW_W-1:0] cur_row  = '0;

    t_pixel    pix_expected[$];
    t_dir_step dir_tbl[$];

    int unsigned err_cnt    = 0;
    int unsigned n_requests = 0;
    int unsigned n_pixels   = 0;
    int unsigned n_cfg      = 0;
    int unsigned in_stalls  = 0;
    int unsigned cyc        = 0;
    int unsigned burst_left = 0;
    bit          no_gap     = 1'b0;

    // receiver pattern state
    int unsigned hold_req   = 0;
    int unsigned hold_left  = 0;
    int unsigned pat_left   = 0;
    int unsigned stall_mode = 0;
    logic [15:0] stall_mask = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d pixels still expected",
                     cyc, pix_expected.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    // coordinates of the visible set bits of one byte, then advance through the padded row
    task automatic unpack_byte(input logic [DATA_W-1:0] b, input bit keep);
        int unsigned w;
        int unsigned row_len;
        int unsigned col;
        int          last_k;
        t_pixel      p;
        w       = eff_dim(img_w, MAX_W);
        row_len = ((w + 31) / 32) * 4;
        last_k  = -1;
        for (int k = 0; k < 8; k++) begin
            col = byte_pos * 8 + k;
            if (col < w && b[7-k])
                last_k = k;
        end
        for (int k = 0; k < 8; k++) begin
            col = byte_pos * 8 + k;
            if (col < w && b[7-k] && keep) begin
                p.col  = col[COL_W-1:0];
                p.row  = cur_row;
                p.last = (k == last_k);
                pix_expected = {pix_expected, p};
            end
        end
        byte_pos++;
        if (byte_pos >= row_len) begin
            byte_pos = 0;
            if (cur_row == 0)
                cur_row = ROW_W'(eff_dim(img_h, MAX_H) - 1);
            else
                cur_row = cur_row - 1'b1;
        end
    endtask

    task automatic flag(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // stop offering, wait for every pixel, then let zero-pixel bytes leave the front end
    task automatic settle_idle();
        i_valid = 1'b0;
        while (pix_expected.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        settle_idle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        if (idx == CFG_IDX_WIDTH)
            img_w = val;
        else if (idx == CFG_IDX_HEIGHT)
            img_h = val;
        if (idx == CFG_IDX_WIDTH || idx == CFG_IDX_HEIGHT) begin
            byte_pos = 0;
            cur_row  = ROW_W'(eff_dim(img_h, MAX_H) - 1);
        end
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one request; typed rows push their hand-written pixel instead of the predicted ones
    task automatic send_byte(input logic [DATA_W-1:0] b, input bit typed, input bit hit,
                             input logic [COL_W-1:0] tcol, input logic [ROW_W-1:0] trow);
        int unsigned gap;
        t_pixel      p;
        if (burst_left == 0 && !no_gap) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                i_valid     = 1'b0;
                i_data_byte = DATA_W'($urandom_range(0, 255));
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left != 0)
            burst_left--;
        i_valid     = 1'b1;
        i_data_byte = b;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
            in_stalls++;
        end
        unpack_byte(b, !typed);
        if (typed && hit) begin
            p.col  = tcol;
            p.row  = trow;
            p.last = 1'b1;
            pix_expected = {pix_expected, p};
        end
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic tbl_add(input t_step_kind kind, input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val, input bit typed, input bit hit,
                           input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        t_dir_step s;
        s.kind  = kind;
        s.idx   = idx;
        s.val   = val;
        s.typed = typed;
        s.hit   = hit;
        s.col   = col;
        s.row   = row;
        dir_tbl = {dir_tbl, s};
    endtask

    // receiver: long hold-offs on request, otherwise a randomly changing stall pattern
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (pat_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mask = 16'($urandom);
            pat_left   = $urandom_range(20, 80);
        end else begin
            pat_left--;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= stall_mask[cyc % 16];
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_pixels++;
            if (pix_expected.size() == 0) begin
                flag($sformatf("unexpected pixel col=%0d row=%0d last=%0b",
                               o_pixel_col, o_pixel_row, o_last));
            end else begin
                e = pix_expected.pop_front();
                if (o_pixel_col !== e.col || o_pixel_row !== e.row || o_last !== e.last)
                    flag($sformatf({"pixel exp col=%0d row=%0d last=%0b, ",
                                    "got col=%0d row=%0d last=%0b"},
                                   e.col, e.row, e.last, o_pixel_col, o_pixel_row, o_last));
            end
        end
    end

    initial begin
        int unsigned      w;
        int unsigned      h;
        logic [DATA_W-1:0] b;
        t_dir_step        s;

        // after reset: width 1, height 1, four bytes per row, only column 0 visible
        tbl_add(STEP_PIX, '0, 13'h80, 1, 1, 12'd0, 12'd0);
        tbl_add(STEP_PIX, '0, 13'hFF, 1, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h00, 1, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h00, 1, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'hFF, 1, 1, 12'd0, 12'd0);
        // width 0 behaves as 1
        tbl_add(STEP_CFG, CFG_IDX_WIDTH, 13'd0, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h7F, 1, 0, '0, '0);
        // oversize width and height clamp to the maximum
        tbl_add(STEP_CFG, CFG_IDX_WIDTH, 13'h1FFF, 0, 0, '0, '0);
        tbl_add(STEP_CFG, CFG_IDX_HEIGHT, 13'h1FFF, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h01, 1, 1, 12'd7, 12'd4095);
        tbl_add(STEP_PIX, '0, 13'hFF, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h00, 1, 0, '0, '0);
        tbl_add(STEP_CFG, CFG_IDX_HEIGHT, 13'd0, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h80, 1, 1, 12'd0, 12'd0);
        // unused indexes leave the frame position alone
        tbl_add(STEP_CFG, CFG_IDX_SPARE_A, 13'h1FFF, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h80, 0, 0, '0, '0);
        tbl_add(STEP_CFG, CFG_IDX_SPARE_B, 13'd0, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h40, 0, 0, '0, '0);
        // width 12: partial second byte, padding bytes, row step
        tbl_add(STEP_CFG, CFG_IDX_WIDTH, 13'd12, 0, 0, '0, '0);
        tbl_add(STEP_CFG, CFG_IDX_HEIGHT, 13'd3, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'hA5, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'hFF, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h3C, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'hC3, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h5A, 0, 0, '0, '0);
        // width 32: no extra padding word
        tbl_add(STEP_CFG, CFG_IDX_WIDTH, 13'd32, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'hFF, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'hFF, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'hFF, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h81, 0, 0, '0, '0);
        tbl_add(STEP_PIX, '0, 13'h81, 0, 0, '0, '0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < dir_tbl.size(); k++) begin
            s = dir_tbl[k];
            if (s.kind == STEP_CFG)
                write_reg(s.idx, s.val);
            else
                send_byte(s.val[DATA_W-1:0], s.typed, s.hit, s.col, s.row);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       w = 0;
                1:       w = MAX_W;
                2:       w = $urandom_range(MAX_W + 1, 8191);
                3:       w = 32 * $urandom_range(1, 4);
                default: w = $urandom_range(1, 70);
            endcase
            case ($urandom_range(0, 7))
                0:       h = 0;
                1:       h = MAX_H;
                2:       h = 8191;
                default: h = $urandom_range(1, 5);
            endcase
            if (ph == PRESSURE_PHASE)
                w = MAX_W;
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_IDX_WIDTH, w[CFG_W-1:0]);
                write_reg(CFG_IDX_HEIGHT, h[CFG_W-1:0]);
            end else begin
                write_reg(CFG_IDX_HEIGHT, h[CFG_W-1:0]);
                write_reg(CFG_IDX_WIDTH, w[CFG_W-1:0]);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                          CFG_W'($urandom_range(0, 8191)));
            // output held off while the input keeps pushing full bytes, so the queue backs up
            if (ph == PRESSURE_PHASE) begin
                no_gap   = 1'b1;
                hold_req = HOLD_CYCLES;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == DRAIN_PHASE && k == ITEMS_PER_PHASE / 2)
                    settle_idle();
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = DATA_W'($urandom_range(0, 255));
                endcase
                if (ph == PRESSURE_PHASE)
                    b = 8'hFF;
                send_byte(b, 1'b0, 1'b0, '0, '0);
            end
            no_gap = 1'b0;
        end

        settle_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run: %0d byte requests, %0d pixels checked, %0d register writes",
                 n_requests, n_pixels, n_cfg);
        $display("run: %0d cycles with the input stalled, %0d errors", in_stalls, err_cnt);
        if (err_cnt == 0 && pix_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
